/* src/slbe_pkg.sv */
// ----------------------------------------------------------------------------
// slbe_pkg
// Shared types and constants for the string literal body encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package slbe_pkg;

    localparam int unsigned QueueDepth = 4;

    // register indexes on the configuration port
    localparam logic [0:0] REG_UNIT_WIDTH = 1'b0;
    localparam logic [0:0] REG_RAW_MODE   = 1'b1;

    // unit width codes (the top code behaves as thirty-two-bit)
    localparam logic [1:0] UW_8      = 2'd0;
    localparam logic [1:0] UW_16     = 2'd1;
    localparam logic [1:0] UW_32     = 2'd2;
    localparam logic [1:0] UW_32_ALT = 2'd3;

    // work handed from the front part to the back part
    typedef struct packed {
        logic [3:0]  nbytes;   // bytes to emit, 0 for status only
        logic        done;     // final byte of the body
        logic        ok;       // body status with done
    } t_job;

    // one job expanded to up to eight bytes
    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
    } t_bytes;

    // encode a character (or unit) into its byte sequence
    function automatic t_bytes enc_char(input logic [32:0] cp, input logic [1:0] uw,
                                        output logic bad);
        t_bytes      r;
        logic [31:0] v;
        logic [19:0] s;
        logic [15:0] ld;
        logic [15:0] tr;
        r   = '0;
        bad = 1'b0;
        v   = cp[31:0];
        s   = 20'(v - 32'h10000);
        ld  = 16'hD800 + 16'(s[19:10]);
        tr  = 16'hDC00 + 16'(s[9:0]);
        if (uw[1]) begin
            if (cp[32]) bad = 1'b1;
            r.bytes = {32'd0, v};
            r.count = 4'd4;
        end else if (cp > 33'h10FFFF) begin
            bad = 1'b1;
        end else if (uw[0]) begin
            if (v < 32'h10000) begin
                r.bytes = {48'd0, v[15:0]};
                r.count = 4'd2;
            end else begin
                r.bytes = {32'd0, tr, ld};
                r.count = 4'd4;
            end
        end else if (v < 32'h80) begin
            r.bytes = {56'd0, v[7:0]};
            r.count = 4'd1;
        end else if (v < 32'h800) begin
            r.bytes = {48'd0, 2'b10, v[5:0], 3'b110, v[10:6]};
            r.count = 4'd2;
        end else if (v < 32'h10000) begin
            r.bytes = {40'd0, 2'b10, v[5:0], 2'b10, v[11:6], 4'b1110, v[15:12]};
            r.count = 4'd3;
        end else begin
            r.bytes = {32'd0, 2'b10, v[5:0], 2'b10, v[11:6], 2'b10, v[17:12],
                       5'b11110, v[20:18]};
            r.count = 4'd4;
        end
        // an unencodable character adds nothing
        if (bad) r = '0;
        return r;
    endfunction

    // numeric escape unit, range-checked against the unit width
    function automatic t_bytes enc_unit(input logic [32:0] val, input logic [1:0] uw,
                                        output logic bad);
        t_bytes r;
        r       = '0;
        r.bytes = {32'd0, val[31:0]};
        if (uw[1]) begin
            bad     = val[32];
            r.count = 4'd4;
        end else if (uw[0]) begin
            bad     = |val[32:16];
            r.count = 4'd2;
        end else begin
            bad     = |val[32:8];
            r.count = 4'd1;
        end
        if (bad) r.count = 4'd0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/string_literal_body_encoder_core.sv */
// ----------------------------------------------------------------------------
// string_literal_body_encoder_core
// C++ string literal body encoder: UTF-8 and escapes in, code unit bytes out.
// ----------------------------------------------------------------------------
// The front part decodes one body byte per cycle while the queue is not full,
// into at most one job of up to eight output bytes (a flushed escape unit plus
// one character); a four-entry queue separates it from the back part, which
// emits one result per cycle while i_ready is high. A job is registered in the
// queue before the back part reads it. A job gives one result per byte (or
// one status-only result), so a UTF-32 character takes four results at the
// single-byte output port; the input stalls while the queue holds four jobs.
`default_nettype none

module string_literal_body_encoder_core #(
    parameter int unsigned QDepth = slbe_pkg::QueueDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_body_byte,
    input  wire logic       i_body_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_run_last,
    output logic            o_body_done,
    output logic            o_body_ok
);
    import slbe_pkg::*;

    logic [1:0] r_unit_width_mode;
    logic       r_raw_mode;
    logic       push, full, pop, empty;
    t_job       fj, bj;
    logic [63:0] fb;
    logic [63:0] qb;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_width_mode <= UW_8;
            r_raw_mode        <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_UNIT_WIDTH) r_unit_width_mode <= i_cfg_data;
            else                               r_raw_mode        <= i_cfg_data[0];
        end
    end

    slbe_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_byte(i_body_byte), .i_last(i_body_last),
        .i_unit_width_mode(r_unit_width_mode), .i_raw_mode(r_raw_mode),
        .o_push(push), .o_bytes(fb), .o_job(fj), .i_q_full(full)
    );

    slbe_queue #(.Depth(QDepth)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_bytes(fb), .i_job(fj),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_bytes(qb), .o_job(bj)
    );

    slbe_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_bytes(qb), .i_job(bj), .o_pop(pop),
        .o_valid, .i_ready, .o_out_byte, .o_byte_valid, .o_run_last,
        .o_body_done, .o_body_ok
    );

endmodule

`default_nettype wire

/* src/slbe_front.sv */
// ----------------------------------------------------------------------------
// slbe_front
// Decodes body bytes (UTF-8 and escapes) into one output job per item.
// ----------------------------------------------------------------------------
`default_nettype none

module slbe_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    input  wire logic [1:0]     i_unit_width_mode,
    input  wire logic           i_raw_mode,
    output logic                o_push,
    output logic [63:0]         o_bytes,
    output slbe_pkg::t_job      o_job,
    input  wire logic           i_q_full
);
    import slbe_pkg::*;

    typedef enum logic [5:0] {
        PH_PLAIN = 6'b000001,
        PH_CONT  = 6'b000010,
        PH_ESC   = 6'b000100,
        PH_OCT   = 6'b001000,
        PH_HEX   = 6'b010000,
        PH_UCN   = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [32:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    logic [1:0]  r_cont, n_cont;
    logic        r_failed, n_failed;

    // packed emission: up to eight bytes (escape flush plus one character)
    logic [63:0] em_bytes;
    logic [3:0]  em_count;
    logic        fl;
    logic [7:0]  b;
    logic [4:0]  h;
    logic        is_hex, is_oct, take;
    t_bytes      eb;
    logic        bad;
    logic [7:0]  esc_v;
    logic        esc_hit;

    assign o_ready = !i_q_full;
    assign take    = i_valid && o_ready;
    assign b       = i_byte;
    assign is_oct  = (b >= 8'h30) && (b <= 8'h37);

    // hex digit value, bit 4 marks a digit
    always_comb begin
        h = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) h = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) h = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) h = {1'b1, 4'(b - 8'h37)};
        is_hex = h[4];
    end

    // simple escape lookup
    always_comb begin
        esc_hit = 1'b1;
        unique case (b)
            8'h27, 8'h22, 8'h3F, 8'h5C: esc_v = b;
            8'h61: esc_v = 8'h07;
            8'h62: esc_v = 8'h08;
            8'h66: esc_v = 8'h0C;
            8'h6E: esc_v = 8'h0A;
            8'h72: esc_v = 8'h0D;
            8'h74: esc_v = 8'h09;
            8'h76: esc_v = 8'h0B;
            default: begin esc_v = 8'h00; esc_hit = 1'b0; end
        endcase
    end

    // append a byte group to the emission
    function automatic logic [63:0] app(input logic [63:0] cur, input logic [3:0] n,
                                        input t_bytes x);
        return cur | (x.bytes << {n[2:0], 3'b000});
    endfunction

    // decode step
    always_comb begin
        logic [32:0] hx;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_cont   = r_cont;
        n_failed = r_failed;
        em_bytes = '0;
        em_count = '0;
        fl       = 1'b0;
        eb       = '0;
        bad      = 1'b0;
        hx       = '0;
        if (!r_failed) begin
            // flush a pending octal or hex escape ended by this byte
            if (r_phase == PH_OCT && !is_oct) begin
                fl = 1'b1;
            end else if (r_phase == PH_HEX && !is_hex) begin
                if (r_cnt == 4'd0) n_failed = 1'b1;
                else fl = 1'b1;
            end
            if (fl) begin
                eb = enc_unit(r_acc, i_unit_width_mode, bad);
                if (bad) n_failed = 1'b1;
                em_bytes = eb.bytes;
                em_count = eb.count;
                n_phase  = PH_PLAIN;
            end
            if (!n_failed) begin
                unique case (fl ? PH_PLAIN : r_phase)
                    PH_PLAIN: begin
                        if (b == 8'h5C && !i_raw_mode) begin
                            n_phase = PH_ESC;
                        end else if (b < 8'h80) begin
                            eb = enc_char({25'd0, b}, i_unit_width_mode, bad);
                            n_failed = bad;
                            em_bytes = app(em_bytes, em_count, eb);
                            em_count = em_count + eb.count;
                        end else if (b[7:5] == 3'b110) begin
                            n_acc = {28'd0, b[4:0]}; n_cont = 2'd1; n_phase = PH_CONT;
                        end else if (b[7:4] == 4'b1110) begin
                            n_acc = {29'd0, b[3:0]}; n_cont = 2'd2; n_phase = PH_CONT;
                        end else if (b[7:3] == 5'b11110) begin
                            n_acc = {30'd0, b[2:0]}; n_cont = 2'd3; n_phase = PH_CONT;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_CONT: begin
                        if (b[7:6] != 2'b10) begin
                            n_failed = 1'b1;
                        end else begin
                            n_acc  = {r_acc[26:0], b[5:0]};
                            n_cont = r_cont - 2'd1;
                            if (n_cont == 2'd0) begin
                                n_phase = PH_PLAIN;
                                eb = enc_char(n_acc, i_unit_width_mode, bad);
                                n_failed = bad;
                                em_bytes = eb.bytes;
                                em_count = eb.count;
                            end
                        end
                    end
                    PH_ESC: begin
                        if (esc_hit) begin
                            n_phase = PH_PLAIN;
                            eb = enc_char({25'd0, esc_v}, i_unit_width_mode, bad);
                            n_failed = bad;
                            em_bytes = eb.bytes;
                            em_count = eb.count;
                        end else begin
                            n_acc = '0;
                            if (is_oct) begin
                                n_acc = {30'd0, b[2:0]}; n_cnt = 4'd1; n_phase = PH_OCT;
                            end else if (b == 8'h78) begin
                                n_cnt = 4'd0; n_phase = PH_HEX;
                            end else if (b == 8'h75) begin
                                n_cnt = 4'd4; n_phase = PH_UCN;
                            end else if (b == 8'h55) begin
                                n_cnt = 4'd8; n_phase = PH_UCN;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                    end
                    PH_OCT: begin
                        n_acc = {r_acc[29:0], b[2:0]};
                        n_cnt = r_cnt + 4'd1;
                        if (n_cnt >= 4'd3) begin
                            n_phase = PH_PLAIN;
                            eb = enc_unit(n_acc, i_unit_width_mode, bad);
                            n_failed = bad;
                            em_bytes = eb.bytes;
                            em_count = eb.count;
                        end
                    end
                    PH_HEX: begin
                        // saturate at 2^32
                        hx = (r_acc[32] || (|r_acc[31:28])) ? 33'h100000000
                                                             : {r_acc[28:0], h[3:0]};
                        n_acc = hx;
                        n_cnt = 4'd1;
                    end
                    PH_UCN: begin
                        if (!is_hex) begin
                            n_failed = 1'b1;
                        end else begin
                            n_acc = {r_acc[28:0], h[3:0]};
                            n_cnt = r_cnt - 4'd1;
                            if (n_cnt == 4'd0) begin
                                n_phase = PH_PLAIN;
                                eb = enc_char(n_acc, i_unit_width_mode, bad);
                                n_failed = bad;
                                em_bytes = eb.bytes;
                                em_count = eb.count;
                            end
                        end
                    end
                    default: n_phase = PH_PLAIN;
                endcase
            end
            // end of body flush
            if (i_last && !n_failed) begin
                if (n_phase == PH_OCT || (n_phase == PH_HEX && n_cnt != 4'd0)) begin
                    eb = enc_unit(n_acc, i_unit_width_mode, bad);
                    n_failed = bad;
                    em_bytes = eb.bytes;
                    em_count = eb.count;
                end else if (n_phase != PH_PLAIN) begin
                    n_failed = 1'b1;
                end
            end
            // bytes emitted ahead of a failure still go out
            if (n_failed) begin
                n_phase = PH_PLAIN;
            end
        end
    end

    // one job per item: its bytes, or a status-only job on the final byte
    // (a flush carries at most four bytes; one character at most four more)
    assign o_bytes = em_bytes;

    always_comb begin
        o_job        = '0;
        o_job.nbytes = em_count;
        o_job.done   = i_last;
        o_job.ok     = !n_failed;
        o_push       = take && (em_count != 4'd0 || i_last);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PLAIN;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_cont   <= '0;
            r_failed <= 1'b0;
        end else if (take) begin
            if (i_last) begin
                r_phase  <= PH_PLAIN;
                r_acc    <= '0;
                r_cnt    <= '0;
                r_cont   <= '0;
                r_failed <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_cnt    <= n_cnt;
                r_cont   <= n_cont;
                r_failed <= n_failed;
            end
        end
    end

endmodule

`default_nettype wire

/* src/slbe_queue.sv */
// ----------------------------------------------------------------------------
// slbe_queue
// Short queue of jobs (with up to eight bytes) between front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module slbe_queue #(
    parameter int unsigned Depth = slbe_pkg::QueueDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire logic [63:0]    i_bytes,
    input  wire slbe_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [63:0]         o_bytes,
    output slbe_pkg::t_job      o_job
);
    import slbe_pkg::*;

    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

    logic [63:0] r_bytes [Depth];
    t_job        r_jobs  [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;

    assign o_full  = (r_cnt == (Aw+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_bytes = r_bytes[r_rp];
    assign o_job   = r_jobs[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_bytes[r_wp] <= i_bytes;
            r_jobs[r_wp]  <= i_job;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(i_push) - (Aw+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* src/slbe_back.sv */
// ----------------------------------------------------------------------------
// slbe_back
// Serializes each queued job into result items, one byte per cycle while i_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module slbe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire logic [63:0]    i_bytes,
    input  wire slbe_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_run_last,
    output logic                o_body_done,
    output logic                o_body_ok
);
    import slbe_pkg::*;

    logic [2:0] r_idx;
    logic       last_b;
    logic       adv;
    logic [3:0] nb;

    assign nb      = i_job.nbytes;
    assign last_b  = (nb == 4'd0) || ({1'b0, r_idx} == nb - 4'd1);
    assign o_valid = !i_empty;
    assign adv     = o_valid && i_ready;
    assign o_pop   = adv && last_b;

    // result fields from the head job
    always_comb begin
        o_out_byte   = (nb == 4'd0) ? 8'd0 : i_bytes[{r_idx, 3'b000} +: 8];
        o_byte_valid = (nb != 4'd0);
        o_run_last   = last_b;
        o_body_done  = last_b && i_job.done;
        o_body_ok    = last_b && i_job.done && i_job.ok;
    end

    // byte index within the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= '0;
        else if (adv) r_idx <= last_b ? 3'd0 : r_idx + 3'd1;
    end

endmodule

`default_nettype wire

/* src/slbe_checker.sv */
// ----------------------------------------------------------------------------
// slbe_port_checks
// Port-level checks on the encoder's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module slbe_port_checks (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_byte_valid,
    input wire logic       o_run_last,
    input wire logic       o_body_done,
    input wire logic       o_body_ok,
    input wire logic [7:0] o_out_byte
);
    // status only results carry a zero byte and end their run
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_out_byte == 8'd0 && o_run_last)
        else $error("status result malformed");

    // done only on a run's last result
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_body_done |-> o_run_last)
        else $error("done off run end");

    // ok only with done
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_body_ok |-> o_body_done)
        else $error("ok without done");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte))
        else $error("stalled result changed");
endmodule

bind string_literal_body_encoder_core slbe_port_checks u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_byte_valid, .o_run_last,
    .o_body_done, .o_body_ok, .o_out_byte
);

`default_nettype wire
